// ===== hdl/sas_pkg.sv =====
// ============================================================================
// Sprite animation sequencer package
// Shared constants, command codes and the animation descriptor layout.
// ============================================================================
package sas_pkg;

    localparam int NUM_ANIMS  = 16;
    localparam int COORD_BITS = 12;
    localparam int FRAME_BITS = 8;
    localparam int SEL_BITS   = 4;
    localparam int DT_BITS    = 20;
    localparam int TIME_BITS  = DT_BITS + 1;
    localparam int ANIM_BITS  = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;

    localparam logic [SEL_BITS:0]     NUM_ANIMS_W   = (SEL_BITS + 1)'(NUM_ANIMS);
    localparam logic [DT_BITS-1:0]    DUR_RESET     = DT_BITS'(100000);
    localparam logic [COORD_BITS-1:0] SHEET_W_RESET = COORD_BITS'(1024);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_PLAY   = 2'd1,
        CMD_DEFINE = 2'd2,
        CMD_LOOP   = 2'd3
    } cmd_t;

    // One animation entry as stored in the descriptor RAM.
    typedef struct packed {
        logic [FRAME_BITS-1:0] count;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [DT_BITS-1:0]    dur;
    } anim_desc_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } coord_pair_t;

    localparam anim_desc_t DESC_RESET = '{
        count: '0, sx: '0, sy: '0, w: '0, h: '0, dur: DUR_RESET
    };

endpackage

// ===== hdl/sas_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ============================================================================
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sprite_animation_sequencer.sv =====
// ============================================================================
// Sprite animation sequencer
// Steps a frame rectangle across a sprite sheet from tick, play, define and
// set-loop commands; one result beat per command beat.
// ============================================================================
// Takes one command beat per cycle while in_stall is low. At acceptance a
// define writes its descriptor into the descriptor RAM and a play reads the
// selected descriptor; when the beat leaves the accept stage the playing
// state (frame, time, position, cached descriptor of the playing animation)
// is updated and the result is registered. The output register lets a new
// beat enter while a result waits; stall on the output holds both stages.
// Entries never defined read as zero size, zero frames, 100000 us duration.
// The sheet width register is written through cfg_data with cfg_ready always
// high; write it only while no command is in flight.
module sprite_animation_sequencer
    import sas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COORD_BITS-1:0] cfg_data,
    // command channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [DT_BITS-1:0]    elapsed_us,
    input  logic [SEL_BITS-1:0]   anim_sel,
    input  logic [FRAME_BITS-1:0] frame_total,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] frame_w,
    input  logic [COORD_BITS-1:0] frame_h,
    input  logic [DT_BITS-1:0]    frame_duration,
    input  logic                  loop_on,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] rect_x,
    output logic [COORD_BITS-1:0] rect_y,
    output logic [COORD_BITS-1:0] rect_w,
    output logic [COORD_BITS-1:0] rect_h,
    output logic [FRAME_BITS-1:0] frame_index,
    output logic [SEL_BITS-1:0]   anim_index,
    output logic                  finished,
    output logic                  frame_changed
);

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [COORD_BITS:0] v);
        return v[COORD_BITS] ? {COORD_BITS{1'b1}} : v[COORD_BITS-1:0];
    endfunction

    // Corner of frame 0; drop to the next row when the first frame overhangs.
    function automatic coord_pair_t frame0_pos(input anim_desc_t d,
                                               input logic [COORD_BITS-1:0] sw);
        logic [COORD_BITS:0] xe;
        logic [COORD_BITS:0] ye;
        coord_pair_t         p;
        xe = {1'b0, d.sx} + {1'b0, d.w};
        ye = {1'b0, d.sy} + {1'b0, d.h};
        if (xe > {1'b0, sw})
        begin
            p.x = '0;
            p.y = sat_coord(ye);
        end
        else
        begin
            p.x = d.sx;
            p.y = d.sy;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic advance;
    logic accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            out_valid_reg <= advance || (out_valid_reg && out_stall);
        end
    end

    // ------------------------------------------------------------------
    // Sheet width register
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] sheet_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sheet_width_reg <= SHEET_W_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sheet_width_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: descriptor RAM write (define) and read (play)
    // ------------------------------------------------------------------
    cmd_t                 in_cmd;
    logic                 in_sel_ok;
    logic [ANIM_BITS-1:0] in_idx;
    anim_desc_t           in_desc;
    anim_desc_t           ram_q;
    logic                 ram_wr;
    logic                 ram_rd;
    logic [NUM_ANIMS-1:0] desc_valid_reg;

    assign in_cmd    = cmd_t'(cmd);
    assign in_sel_ok = {1'b0, anim_sel} < NUM_ANIMS_W;
    assign in_idx    = anim_sel[ANIM_BITS-1:0];
    assign in_desc   = '{count: frame_total, sx: start_x, sy: start_y,
                         w: frame_w, h: frame_h, dur: frame_duration};
    assign ram_wr    = accept && in_sel_ok && (in_cmd == CMD_DEFINE);
    assign ram_rd    = accept && (in_cmd == CMD_PLAY);

    sas_ram #(
        .WIDTH ($bits(anim_desc_t)),
        .DEPTH (NUM_ANIMS)
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (in_idx),
        .wr_data (in_desc),
        .rd_en   (ram_rd),
        .rd_addr (in_idx),
        .rd_data (ram_q)
    );

    logic s1_rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg  <= '0;
            s1_rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_wr)
            begin
                desc_valid_reg[in_idx] <= 1'b1;
            end
            if (ram_rd)
            begin
                s1_rd_valid_reg <= desc_valid_reg[in_idx];
            end
        end
    end

    // Command beat held for the update stage
    cmd_t                  s1_cmd_reg;
    logic [DT_BITS-1:0]    s1_dt_reg;
    logic [SEL_BITS-1:0]   s1_sel_reg;
    anim_desc_t            s1_desc_reg;
    logic                  s1_loop_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= in_cmd;
            s1_dt_reg   <= elapsed_us;
            s1_sel_reg  <= anim_sel;
            s1_desc_reg <= in_desc;
            s1_loop_reg <= loop_on;
        end
    end

    // ------------------------------------------------------------------
    // Update stage: playing state
    // ------------------------------------------------------------------
    logic [SEL_BITS-1:0]   anim_reg,   anim_next;
    logic [FRAME_BITS-1:0] frame_reg,  frame_next;
    logic [TIME_BITS-1:0]  time_reg,   time_next;
    logic [COORD_BITS-1:0] pos_x_reg,  pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg,  pos_y_next;
    anim_desc_t            cur_reg,    cur_next;
    logic [NUM_ANIMS-1:0]  loop_reg,   loop_next;

    logic                  s1_sel_ok;
    logic [ANIM_BITS-1:0]  s1_idx;
    logic [ANIM_BITS-1:0]  anim_idx;
    logic [ANIM_BITS-1:0]  anim_next_idx;
    anim_desc_t            ram_desc;
    anim_desc_t            f0_desc;
    coord_pair_t           f0;

    assign s1_sel_ok     = {1'b0, s1_sel_reg} < NUM_ANIMS_W;
    assign s1_idx        = s1_sel_reg[ANIM_BITS-1:0];
    assign anim_idx      = anim_reg[ANIM_BITS-1:0];
    assign anim_next_idx = anim_next[ANIM_BITS-1:0];
    assign ram_desc      = s1_rd_valid_reg ? ram_q : DESC_RESET;

    always_comb
    begin
        case (s1_cmd_reg)
            CMD_PLAY:   f0_desc = ram_desc;
            CMD_DEFINE: f0_desc = s1_desc_reg;
            default:    f0_desc = cur_reg;
        endcase
    end

    assign f0 = frame0_pos(f0_desc, sheet_width_reg);

    // Tick arithmetic: saturating accumulate, then take one duration off.
    logic [TIME_BITS:0]    tick_sum;
    logic [TIME_BITS-1:0]  tick_sat;
    logic                  tick_due;
    logic [TIME_BITS-1:0]  tick_rem;
    logic [FRAME_BITS:0]   frame_inc;
    logic                  on_last;

    assign tick_sum  = {1'b0, time_reg} + (TIME_BITS + 1)'(s1_dt_reg);
    assign tick_sat  = tick_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : tick_sum[TIME_BITS-1:0];
    assign tick_due  = tick_sat >= TIME_BITS'(cur_reg.dur);
    assign tick_rem  = tick_sat - TIME_BITS'(cur_reg.dur);
    assign frame_inc = {1'b0, frame_reg} + (FRAME_BITS + 1)'(1);
    assign on_last   = frame_inc >= {1'b0, cur_reg.count};

    // Next frame position: step right, or wrap to the next row.
    logic [COORD_BITS:0]   step_nx;
    logic [COORD_BITS+1:0] step_far;
    logic                  step_wrap;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;

    assign step_nx   = {1'b0, pos_x_reg} + {1'b0, cur_reg.w};
    assign step_far  = {1'b0, step_nx} + {2'b0, cur_reg.w};
    assign step_wrap = step_far > {2'b0, sheet_width_reg};
    assign step_x    = step_wrap ? '0 : step_nx[COORD_BITS-1:0];
    assign step_y    = step_wrap ? sat_coord({1'b0, pos_y_reg} + {1'b0, cur_reg.h})
                                 : pos_y_reg;

    always_comb
    begin
        anim_next  = anim_reg;
        frame_next = frame_reg;
        time_next  = time_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        cur_next   = cur_reg;
        loop_next  = loop_reg;
        unique case (s1_cmd_reg)
            CMD_TICK:
            begin
                time_next = tick_due ? tick_rem : tick_sat;
                if (tick_due && (cur_reg.count != '0))
                begin
                    if (loop_reg[anim_idx] && on_last)
                    begin
                        // wrap to frame 0, keep the leftover time
                        frame_next = '0;
                        pos_x_next = f0.x;
                        pos_y_next = f0.y;
                    end
                    else if (!on_last)
                    begin
                        frame_next = frame_inc[FRAME_BITS-1:0];
                        pos_x_next = step_x;
                        pos_y_next = step_y;
                    end
                end
            end
            CMD_PLAY:
            begin
                if (s1_sel_ok && (s1_sel_reg != anim_reg))
                begin
                    anim_next  = s1_sel_reg;
                    cur_next   = ram_desc;
                    frame_next = '0;
                    time_next  = '0;
                    pos_x_next = f0.x;
                    pos_y_next = f0.y;
                end
            end
            CMD_DEFINE:
            begin
                // redefining the playing animation restarts it
                if (s1_sel_ok && (s1_sel_reg == anim_reg))
                begin
                    cur_next   = s1_desc_reg;
                    frame_next = '0;
                    time_next  = '0;
                    pos_x_next = f0.x;
                    pos_y_next = f0.y;
                end
            end
            CMD_LOOP:
            begin
                if (s1_sel_ok)
                begin
                    loop_next[s1_idx] = s1_loop_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_reg  <= '0;
            frame_reg <= '0;
            time_reg  <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            cur_reg   <= DESC_RESET;
            loop_reg  <= '1;
        end
        else if (advance)
        begin
            anim_reg  <= anim_next;
            frame_reg <= frame_next;
            time_reg  <= time_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            cur_reg   <= cur_next;
            loop_reg  <= loop_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                  fin_next;
    logic                  chg_next;
    logic [COORD_BITS-1:0] rect_x_reg;
    logic [COORD_BITS-1:0] rect_y_reg;
    logic [COORD_BITS-1:0] rect_w_reg;
    logic [COORD_BITS-1:0] rect_h_reg;
    logic [FRAME_BITS-1:0] frame_index_reg;
    logic [SEL_BITS-1:0]   anim_index_reg;
    logic                  finished_reg;
    logic                  frame_changed_reg;

    assign fin_next = !loop_next[anim_next_idx] && (cur_next.count != '0)
                      && (frame_next == (cur_next.count - FRAME_BITS'(1)));
    assign chg_next = (pos_x_next != pos_x_reg) || (pos_y_next != pos_y_reg)
                      || (cur_next.w != cur_reg.w) || (cur_next.h != cur_reg.h);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rect_x_reg        <= pos_x_next;
            rect_y_reg        <= pos_y_next;
            rect_w_reg        <= cur_next.w;
            rect_h_reg        <= cur_next.h;
            frame_index_reg   <= frame_next;
            anim_index_reg    <= anim_next;
            finished_reg      <= fin_next;
            frame_changed_reg <= chg_next;
        end
    end

    assign rect_x        = rect_x_reg;
    assign rect_y        = rect_y_reg;
    assign rect_w        = rect_w_reg;
    assign rect_h        = rect_h_reg;
    assign frame_index   = frame_index_reg;
    assign anim_index    = anim_index_reg;
    assign finished      = finished_reg;
    assign frame_changed = frame_changed_reg;

endmodule

// ===== test/sprite_rect_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Sprite rectangle checker
// Follows every accepted register and command beat with its own copy of the
// animation tables and the playing state, predicts the result rectangle of
// each command and compares the result beats, in order, field by field.
// ============================================================================
module sprite_rect_checker
    import sas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [COORD_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [DT_BITS-1:0]    elapsed_us,
    input  logic [SEL_BITS-1:0]   anim_sel,
    input  logic [FRAME_BITS-1:0] frame_total,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] frame_w,
    input  logic [COORD_BITS-1:0] frame_h,
    input  logic [DT_BITS-1:0]    frame_duration,
    input  logic                  loop_on,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [COORD_BITS-1:0] rect_x,
    input  logic [COORD_BITS-1:0] rect_y,
    input  logic [COORD_BITS-1:0] rect_w,
    input  logic [COORD_BITS-1:0] rect_h,
    input  logic [FRAME_BITS-1:0] frame_index,
    input  logic [SEL_BITS-1:0]   anim_index,
    input  logic                  finished,
    input  logic                  frame_changed,
    output int                    mismatches,
    output int                    pending,
    output int                    results_seen
);

    localparam int unsigned TIME_SAT  = (1 << TIME_BITS) - 1;
    localparam int unsigned COORD_MAX = (1 << COORD_BITS) - 1;

    typedef struct packed {
        cmd_t                  op;
        logic [DT_BITS-1:0]    dt;
        logic [SEL_BITS-1:0]   sel;
        anim_desc_t            desc;
        logic                  loop_flag;
    } cmd_beat_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [FRAME_BITS-1:0] frame;
        logic [SEL_BITS-1:0]   anim;
        logic                  fin;
        logic                  chg;
    } sprite_rect_t;

    anim_desc_t            desc_tab [NUM_ANIMS];
    logic                  loop_tab [NUM_ANIMS];
    logic [SEL_BITS-1:0]   cur_anim;
    logic [FRAME_BITS-1:0] cur_frame;
    int unsigned           time_acc;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] sheet_w;
    sprite_rect_t          expected_rects [$];
    cmd_beat_t             seen_beat;
    sprite_rect_t          want;
    sprite_rect_t          got;

    function automatic logic [COORD_BITS-1:0] sat_coord(input int unsigned v);
        return (v > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(v);
    endfunction

    // Put the playing animation on its first frame with no time banked.
    function automatic void rewind_animation();
        int unsigned sx;
        int unsigned sy;
        int unsigned w;
        int unsigned h;
        sx = desc_tab[cur_anim].sx;
        sy = desc_tab[cur_anim].sy;
        w  = desc_tab[cur_anim].w;
        h  = desc_tab[cur_anim].h;
        cur_frame = '0;
        time_acc  = 0;
        if (sx + w > sheet_w)
        begin
            pos_x = '0;
            pos_y = sat_coord(sy + h);
        end
        else
        begin
            pos_x = COORD_BITS'(sx);
            pos_y = COORD_BITS'(sy);
        end
    endfunction

    function automatic void step_right();
        int unsigned w;
        int unsigned h;
        int unsigned nx;
        w  = desc_tab[cur_anim].w;
        h  = desc_tab[cur_anim].h;
        nx = pos_x + w;
        if (nx + w > sheet_w)
        begin
            pos_x = '0;
            pos_y = sat_coord(pos_y + h);
        end
        else
            pos_x = COORD_BITS'(nx);
    endfunction

    function automatic void apply_tick(input int unsigned dt);
        int unsigned t;
        int unsigned dur;
        int unsigned cnt;
        int unsigned keep;
        dur = desc_tab[cur_anim].dur;
        cnt = desc_tab[cur_anim].count;
        t = time_acc + dt;
        if (t > TIME_SAT)
            t = TIME_SAT;
        time_acc = t;
        if (t < dur)
            return;
        time_acc = t - dur;
        // a zero frame count still drains time but never advances
        if (cnt == 0)
            return;
        if (loop_tab[cur_anim])
        begin
            if (cur_frame + 1 >= cnt)
            begin
                keep = time_acc;
                rewind_animation();
                time_acc = keep;
            end
            else
            begin
                cur_frame++;
                step_right();
            end
        end
        else if (cur_frame + 1 < cnt)
        begin
            cur_frame++;
            step_right();
        end
    endfunction

    function automatic sprite_rect_t advance_sprite_state(input cmd_beat_t b);
        sprite_rect_t          r;
        logic [COORD_BITS-1:0] old_x;
        logic [COORD_BITS-1:0] old_y;
        logic [COORD_BITS-1:0] old_w;
        logic [COORD_BITS-1:0] old_h;
        int unsigned           cnt;
        old_x = pos_x;
        old_y = pos_y;
        old_w = desc_tab[cur_anim].w;
        old_h = desc_tab[cur_anim].h;
        case (b.op)
            CMD_TICK:
                apply_tick(b.dt);
            CMD_PLAY:
                if (b.sel != cur_anim)
                begin
                    cur_anim = b.sel;
                    rewind_animation();
                end
            CMD_DEFINE:
            begin
                desc_tab[b.sel] = b.desc;
                if (b.sel == cur_anim)
                    rewind_animation();
            end
            default:
                loop_tab[b.sel] = b.loop_flag;
        endcase
        cnt     = desc_tab[cur_anim].count;
        r.x     = pos_x;
        r.y     = pos_y;
        r.w     = desc_tab[cur_anim].w;
        r.h     = desc_tab[cur_anim].h;
        r.frame = cur_frame;
        r.anim  = cur_anim;
        r.fin   = !loop_tab[cur_anim] && cnt != 0 && cur_frame == cnt - 1;
        r.chg   = old_x != r.x || old_y != r.y || old_w != r.w || old_h != r.h;
        return r;
    endfunction

    task automatic compare_field(input string fname, input int unsigned exp_v,
                                 input int unsigned act_v);
        if (exp_v != act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, fname, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ANIMS; i++)
            begin
                desc_tab[i] = DESC_RESET;
                loop_tab[i] = 1'b1;
            end
            cur_anim     = '0;
            cur_frame    = '0;
            time_acc     = 0;
            pos_x        = '0;
            pos_y        = '0;
            sheet_w      = SHEET_W_RESET;
            expected_rects.delete();
            pending      = 0;
            mismatches   = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sheet_w = cfg_data;
            if (in_valid && !in_stall)
            begin
                seen_beat.op        = cmd_t'(cmd);
                seen_beat.dt        = elapsed_us;
                seen_beat.sel       = anim_sel;
                seen_beat.desc      = '{count: frame_total, sx: start_x, sy: start_y,
                                        w: frame_w, h: frame_h, dur: frame_duration};
                seen_beat.loop_flag = loop_on;
                expected_rects.push_back(advance_sprite_state(seen_beat));
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got = '{x: rect_x, y: rect_y, w: rect_w, h: rect_h, frame: frame_index,
                        anim: anim_index, fin: finished, chg: frame_changed};
                if (expected_rects.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no command waiting", results_seen);
                end
                else
                begin
                    want = expected_rects.pop_front();
                    compare_field("rect_x", want.x, got.x);
                    compare_field("rect_y", want.y, got.y);
                    compare_field("rect_w", want.w, got.w);
                    compare_field("rect_h", want.h, got.h);
                    compare_field("frame_index", want.frame, got.frame);
                    compare_field("anim_index", want.anim, got.anim);
                    compare_field("finished", want.fin, got.fin);
                    compare_field("frame_changed", want.chg, got.chg);
                end
            end
            pending = expected_rects.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Sprite animation sequencer testbench
// Drives directed corner cases and then random define, loop, play and tick
// sequences under several sheet widths, with random gaps on the command side
// and random stalls on the result side; the checker scores every result.
// ============================================================================
module testbench;
    import sas_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASE_BEATS    = 140;
    localparam int unsigned DT_MAX         = (1 << DT_BITS) - 1;
    localparam int unsigned COORD_MAX      = (1 << COORD_BITS) - 1;

    typedef struct {
        cmd_t                op;
        logic [DT_BITS-1:0]  dt;
        logic [SEL_BITS-1:0] sel;
        anim_desc_t          desc;
        logic                loop_flag;
    } sprite_cmd_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [COORD_BITS-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            cmd;
    logic [DT_BITS-1:0]    elapsed_us;
    logic [SEL_BITS-1:0]   anim_sel;
    logic [FRAME_BITS-1:0] frame_total;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] frame_w;
    logic [COORD_BITS-1:0] frame_h;
    logic [DT_BITS-1:0]    frame_duration;
    logic                  loop_on;
    logic                  out_valid;
    logic                  out_stall;
    logic [COORD_BITS-1:0] rect_x;
    logic [COORD_BITS-1:0] rect_y;
    logic [COORD_BITS-1:0] rect_w;
    logic [COORD_BITS-1:0] rect_h;
    logic [FRAME_BITS-1:0] frame_index;
    logic [SEL_BITS-1:0]   anim_index;
    logic                  finished;
    logic                  frame_changed;

    int                    mismatches;
    int                    pending;
    int                    results_seen;
    int                    beats_sent;
    int                    op_counts [4];
    int                    widths_used;
    int                    quiet_cycles;
    int                    phase_end;
    bit                    steady_feed;
    logic [COORD_BITS-1:0] sheet_now;
    logic [COORD_BITS-1:0] phase_widths [5];

    sprite_animation_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .elapsed_us     (elapsed_us),
        .anim_sel       (anim_sel),
        .frame_total    (frame_total),
        .start_x        (start_x),
        .start_y        (start_y),
        .frame_w        (frame_w),
        .frame_h        (frame_h),
        .frame_duration (frame_duration),
        .loop_on        (loop_on),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rect_x         (rect_x),
        .rect_y         (rect_y),
        .rect_w         (rect_w),
        .rect_h         (rect_h),
        .frame_index    (frame_index),
        .anim_index     (anim_index),
        .finished       (finished),
        .frame_changed  (frame_changed)
    );

    sprite_rect_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .elapsed_us     (elapsed_us),
        .anim_sel       (anim_sel),
        .frame_total    (frame_total),
        .start_x        (start_x),
        .start_y        (start_y),
        .frame_w        (frame_w),
        .frame_h        (frame_h),
        .frame_duration (frame_duration),
        .loop_on        (loop_on),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rect_x         (rect_x),
        .rect_y         (rect_y),
        .rect_w         (rect_w),
        .rect_h         (rect_h),
        .frame_index    (frame_index),
        .anim_index     (anim_index),
        .finished       (finished),
        .frame_changed  (frame_changed),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    // Result side: calm stretches, choppy stretches and the odd long stall.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    repeat ($urandom_range(20, 80)) @(negedge clk) out_stall = 1'b0;
                3:
                    repeat ($urandom_range(15, 40)) @(negedge clk) out_stall = 1'b1;
                default:
                    repeat ($urandom_range(10, 40))
                        @(negedge clk) out_stall = ($urandom_range(0, 99) < 35);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [SEL_BITS-1:0] pick_anim();
        if ($urandom_range(0, 3) == 0)
            return SEL_BITS'($urandom_range(0, NUM_ANIMS - 1));
        return SEL_BITS'($urandom_range(0, 3));
    endfunction

    // Every field random, so the bits a command ignores still toggle.
    function automatic sprite_cmd_t scrambled_cmd(input cmd_t op);
        sprite_cmd_t c;
        c.op         = op;
        c.dt         = DT_BITS'($urandom());
        c.sel        = SEL_BITS'($urandom());
        c.desc.count = FRAME_BITS'($urandom());
        c.desc.sx    = COORD_BITS'($urandom());
        c.desc.sy    = COORD_BITS'($urandom());
        c.desc.w     = COORD_BITS'($urandom_range(1, COORD_MAX));
        c.desc.h     = COORD_BITS'($urandom_range(1, COORD_MAX));
        c.desc.dur   = DT_BITS'($urandom());
        c.loop_flag  = 1'($urandom());
        return c;
    endfunction

    function automatic anim_desc_t random_desc();
        anim_desc_t  d;
        int unsigned r;
        int unsigned w_hi;
        r = $urandom_range(0, 9);
        if (r < 6)
            d.count = FRAME_BITS'($urandom_range(1, 8));
        else if (r == 6)
            d.count = '0;
        else if (r == 7)
            d.count = FRAME_BITS'(1);
        else
            d.count = FRAME_BITS'($urandom_range(0, 255));
        d.sx = ($urandom_range(0, 1) != 0) ? COORD_BITS'($urandom_range(0, sheet_now))
                                           : COORD_BITS'($urandom_range(0, COORD_MAX));
        d.sy = ($urandom_range(0, 1) != 0) ? COORD_BITS'($urandom_range(0, 512))
                                           : COORD_BITS'($urandom_range(0, COORD_MAX));
        w_hi = (sheet_now > 7) ? sheet_now / 4 : 1;
        d.w  = ($urandom_range(0, 9) < 7) ? COORD_BITS'($urandom_range(1, w_hi))
                                          : COORD_BITS'($urandom_range(1, COORD_MAX));
        d.h  = ($urandom_range(0, 9) < 7) ? COORD_BITS'($urandom_range(1, 128))
                                          : COORD_BITS'($urandom_range(1, COORD_MAX));
        r = $urandom_range(0, 9);
        if (r < 6)
            d.dur = DT_BITS'($urandom_range(0, 2500));
        else if (r == 6)
            d.dur = '0;
        else if (r < 9)
            d.dur = DT_BITS'($urandom_range(0, DT_MAX));
        else
            d.dur = DT_BITS'(DT_MAX);
        return d;
    endfunction

    // Elapsed time often near one frame duration so frames keep moving.
    function automatic logic [DT_BITS-1:0] random_elapsed(input int unsigned dur);
        int unsigned r;
        int unsigned hi;
        r  = $urandom_range(0, 99);
        hi = (dur * 2 + 1 > DT_MAX) ? DT_MAX : dur * 2 + 1;
        if (r < 45)
            return DT_BITS'($urandom_range(dur / 2, hi));
        if (r < 75)
            return DT_BITS'($urandom_range(0, 3000));
        if (r < 85)
            return '0;
        if (r < 95)
            return DT_BITS'($urandom_range(0, DT_MAX));
        return DT_BITS'(DT_MAX);
    endfunction

    task automatic issue(input sprite_cmd_t c);
        int unsigned gap;
        @(negedge clk);
        cmd            = c.op;
        elapsed_us     = c.dt;
        anim_sel       = c.sel;
        frame_total    = c.desc.count;
        start_x        = c.desc.sx;
        start_y        = c.desc.sy;
        frame_w        = c.desc.w;
        frame_h        = c.desc.h;
        frame_duration = c.desc.dur;
        loop_on        = c.loop_flag;
        in_valid       = 1'b1;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        op_counts[c.op]++;
        gap = steady_feed ? 0 : pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_tick(input int unsigned dt);
        sprite_cmd_t c;
        c    = scrambled_cmd(CMD_TICK);
        c.dt = DT_BITS'(dt);
        issue(c);
    endtask

    task automatic send_play(input logic [SEL_BITS-1:0] sel);
        sprite_cmd_t c;
        c     = scrambled_cmd(CMD_PLAY);
        c.sel = sel;
        issue(c);
    endtask

    task automatic send_loop(input logic [SEL_BITS-1:0] sel, input logic flag);
        sprite_cmd_t c;
        c           = scrambled_cmd(CMD_LOOP);
        c.sel       = sel;
        c.loop_flag = flag;
        issue(c);
    endtask

    task automatic send_define(input logic [SEL_BITS-1:0] sel, input int unsigned count,
                               input int unsigned sx, input int unsigned sy,
                               input int unsigned w, input int unsigned h,
                               input int unsigned dur);
        sprite_cmd_t c;
        c      = scrambled_cmd(CMD_DEFINE);
        c.sel  = sel;
        c.desc = '{count: FRAME_BITS'(count), sx: COORD_BITS'(sx), sy: COORD_BITS'(sy),
                   w: COORD_BITS'(w), h: COORD_BITS'(h), dur: DT_BITS'(dur)};
        issue(c);
    endtask

    // Define an animation, maybe set its loop flag, play it, then tick it along.
    task automatic play_scene();
        sprite_cmd_t         c;
        logic [SEL_BITS-1:0] sel;
        int unsigned         dur;
        sel    = pick_anim();
        c      = scrambled_cmd(CMD_DEFINE);
        c.sel  = sel;
        c.desc = random_desc();
        dur    = c.desc.dur;
        issue(c);
        if ($urandom_range(0, 1) != 0)
            send_loop(sel, 1'($urandom_range(0, 1)));
        send_play(sel);
        repeat ($urandom_range(2, 14))
            send_tick(random_elapsed(dur));
    endtask

    task automatic random_beat();
        sprite_cmd_t c;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            c = scrambled_cmd(CMD_TICK);
        else if (r < 67)
            c = scrambled_cmd(CMD_PLAY);
        else if (r < 84)
            c = scrambled_cmd(CMD_DEFINE);
        else
            c = scrambled_cmd(CMD_LOOP);
        c.sel = pick_anim();
        if (c.op == CMD_TICK)
            c.dt = random_elapsed(1500);
        else if (c.op == CMD_DEFINE)
            c.desc = random_desc();
        issue(c);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_sheet_width(input logic [COORD_BITS-1:0] width);
        settle();
        cfg_valid = 1'b1;
        cfg_data  = width;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        sheet_now = width;
        widths_used++;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        cmd            = CMD_TICK;
        elapsed_us     = '0;
        anim_sel       = '0;
        frame_total    = '0;
        start_x        = '0;
        start_y        = '0;
        frame_w        = COORD_BITS'(1);
        frame_h        = COORD_BITS'(1);
        frame_duration = '0;
        loop_on        = 1'b0;
        quiet_cycles   = 0;
        beats_sent     = 0;
        widths_used    = 0;
        steady_feed    = 1'b0;
        sheet_now      = SHEET_W_RESET;
        op_counts      = '{0, 0, 0, 0};
        phase_widths   = '{12'd1, 12'd4095, 12'd64, 12'd640, 12'd0};
        phase_widths[4] = COORD_BITS'($urandom_range(100, 3000));
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_sheet_width(SHEET_W_RESET);

        // untouched animation 0: time builds up to saturation, frame holds
        repeat (3) send_tick(DT_MAX);
        send_define(4'd1, 4, 100, 200, 32, 48, 1000);
        send_play(4'd1);
        send_tick(1000);
        send_tick(DT_MAX);
        send_tick(0);
        send_loop(4'd1, 1'b0);
        send_tick(5000);
        send_tick(5000);
        // one looping frame: rectangle stays put
        send_define(4'd2, 1, 0, 0, 16, 16, 10);
        send_play(4'd2);
        send_tick(10);
        // zero duration: advance on every tick and wrap rows
        send_define(4'd3, 3, 0, 0, 400, 20, 0);
        send_play(4'd3);
        repeat (3) send_tick(0);
        // first frame past the sheet edge, y saturating
        send_define(4'd4, 255, 4000, 4090, 200, 100, 1);
        send_play(4'd4);
        send_tick(5);
        send_play(4'd4);
        send_define(4'd4, 255, 4095, 4095, 4095, 4095, DT_MAX);
        send_define(4'd15, 0, 0, 0, 1, 1, 0);
        send_loop(4'd15, 1'b1);
        send_play(4'd15);
        send_tick(7);

        foreach (phase_widths[p])
        begin
            write_sheet_width(phase_widths[p]);
            steady_feed = 1'b0;
            phase_end   = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
            begin
                if ($urandom_range(0, 19) == 0)
                    steady_feed = !steady_feed;
                if ($urandom_range(0, 9) < 7)
                    play_scene();
                else
                    random_beat();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        $display("Ran %0d command beats (%0d ticks, %0d plays, %0d defines, %0d loop sets)",
                 beats_sent, op_counts[CMD_TICK], op_counts[CMD_PLAY],
                 op_counts[CMD_DEFINE], op_counts[CMD_LOOP]);
        $display("over %0d sheet widths; %0d results checked, %0d field mismatches.",
                 widths_used, results_seen, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
